// ===== design/gdsa_pkg.sv =====
// Shared types and constants for the goal distance / mean speed block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package gdsa_pkg;

	localparam int DATA_W    = 32;  // Q16.16 fields and registers
	localparam int LEN_W     = 7;   // window_len register
	localparam int CFG_IDX_W = 2;   // configuration register index
	localparam int DIFF_W    = 33;  // signed coordinate difference
	localparam int RAD_W     = 66;  // sum of two squares
	localparam int ROOT_W    = 33;  // floor square root of a RAD_W value

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y   = 2'd2;

	localparam logic [LEN_W-1:0] WINDOW_LEN_RST = 7'd8;

	// status of an iterative arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== design/gdsa_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on gdsa_pkg for widths and the unit status struct.
`timescale 1ns / 1ps

module gdsa_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gdsa_pkg::RAD_W-1:0]  radicand,
	output logic [gdsa_pkg::ROOT_W-1:0] root,
	output gdsa_pkg::unit_stat_t        stat
);
	import gdsa_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;   // remainder stays below 2*root+1
	localparam int SH_W  = REM_W + 2;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [SH_W-1:0] rem_sh_w;
	logic [SH_W-1:0] trial_w;
	logic            take_w;

	assign rem_sh_w = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial_w  = SH_W'({root_q, 2'b01});
	assign take_w   = (rem_sh_w >= trial_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take_w) begin
				rem_q  <= REM_W'(rem_sh_w - trial_w);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_sh_w);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== design/gdsa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gdsa_pkg for the unit status struct.
`timescale 1ns / 1ps

module gdsa_div #(
	parameter int N_W = 38,
	parameter int D_W = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [N_W-1:0]       dividend,
	input  logic [D_W-1:0]       divisor,
	output logic [N_W-1:0]       quotient,
	output gdsa_pkg::unit_stat_t stat
);
	import gdsa_pkg::*;

	localparam int CNT_W = $clog2(N_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   num_q;   // dividend shifts out, quotient shifts in
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;

	logic [D_W:0] rem_sh_w;
	logic         take_w;

	assign rem_sh_w = {rem_q, num_q[N_W-1]};
	assign take_w   = (rem_sh_w >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (take_w) begin
				rem_q <= D_W'(rem_sh_w - {1'b0, den_q});
				num_q <= {num_q[N_W-2:0], 1'b1};
			end else begin
				rem_q <= D_W'(rem_sh_w);
				num_q <= {num_q[N_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== design/goal_distance_speed_average_top.sv =====
// Goal distance and windowed mean speed, top level.
// Depends on gdsa_pkg, gdsa_sqrt and gdsa_div.
//
// Input channel (in_valid / in_stall): one odometry sample per beat, position
// and velocity in signed Q16.16. Output channel (out_valid / out_stall): one
// beat per sample carrying goal_distance and mean_speed, unsigned Q16.16,
// both saturating at 0xFFFFFFFF.
// Configuration: cfg_we with cfg_index 0 (window_len), 1 (target_x) or
// 2 (target_y); write only while the block is idle. Writing window_len
// empties the speed window. Other indexes are ignored.
// One sample is processed at a time: in_stall stays high from acceptance
// until the result is loaded into the output register; the next sample can
// be taken once the block is back in idle. Each sample passes through the
// squaring, the bit-serial square root units (distance and speed in
// parallel) and the bit-serial divider for the mean.
// The speed window lives in a one-port synchronous RAM read and written once
// per sample; a fill count marks slots not yet written, so no clearing pass
// is needed. Reset empties the window and loads window_len = 8, targets 0.
// A stalled result waits in the output register; the next sample is taken
// meanwhile, and its result waits for the register to free up.
`timescale 1ns / 1ps

module goal_distance_speed_average_top #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [gdsa_pkg::DATA_W-1:0]  pos_x,
	input  logic signed [gdsa_pkg::DATA_W-1:0]  pos_y,
	input  logic signed [gdsa_pkg::DATA_W-1:0]  vel_x,
	input  logic signed [gdsa_pkg::DATA_W-1:0]  vel_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [gdsa_pkg::DATA_W-1:0]         goal_distance,
	output logic [gdsa_pkg::DATA_W-1:0]         mean_speed,
	input  logic                                cfg_we,
	input  logic [gdsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gdsa_pkg::DATA_W-1:0]         cfg_data
);
	import gdsa_pkg::*;

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_W = DATA_W + $clog2(WINDOW_MAX);
	localparam int CMP_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SQUARE    = 4'd1;
	localparam logic [3:0] ST_SQRT_GO   = 4'd2;
	localparam logic [3:0] ST_SQRT_WAIT = 4'd3;
	localparam logic [3:0] ST_SUB       = 4'd4;
	localparam logic [3:0] ST_ADD       = 4'd5;
	localparam logic [3:0] ST_DIV_GO    = 4'd6;
	localparam logic [3:0] ST_DIV_WAIT  = 4'd7;
	localparam logic [3:0] ST_OUT       = 4'd8;

	// configuration
	logic [LEN_W-1:0]         window_len_q;
	logic signed [DATA_W-1:0] target_x_q;
	logic signed [DATA_W-1:0] target_y_q;

	// sequencer and window state
	logic [3:0]        state_q;
	logic [2:0]        sq_cnt_q;
	logic [IDX_W-1:0]  slot_q;
	logic [LEN_W-1:0]  fill_q;
	logic [SUM_W-1:0]  sum_q;

	// datapath
	logic signed [DIFF_W-1:0] diff_q [4];
	logic [RAD_W-1:0]  prod_q;
	logic [RAD_W-1:0]  rad_d_q;
	logic [RAD_W-1:0]  rad_s_q;
	logic [DATA_W-1:0] dist_q;
	logic [DATA_W-1:0] speed_q;

	// speed ring
	logic [DATA_W-1:0] ring [WINDOW_MAX];
	logic [DATA_W-1:0] rd_q;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] goal_distance_q;
	logic [DATA_W-1:0] mean_speed_q;

	logic [LEN_W-1:0]         len_w;
	logic [CMP_W-1:0]         slot_x_w;
	logic [CMP_W-1:0]         slot_inc_w;
	logic [CMP_W-1:0]         len_x_w;
	logic [IDX_W-1:0]         slot_eff_w;
	logic [IDX_W-1:0]         slot_next_w;
	logic [1:0]               acc_idx_w;
	logic [DIFF_W-1:0]        mag_w;
	logic [2*DATA_W-1:0]      sq_w;
	logic [SUM_W-1:0]         old_w;
	logic                     in_acc_w;
	logic                     out_free_w;
	logic                     sqrt_start_w;
	logic                     div_start_w;
	logic [ROOT_W-1:0]        root_d_w;
	logic [ROOT_W-1:0]        root_s_w;
	unit_stat_t               sq_d_stat;
	unit_stat_t               sq_s_stat;
	unit_stat_t               div_stat;
	logic [SUM_W-1:0]         quot_w;
	logic [SUM_W:0]           quot_x_w;
	logic [DATA_W-1:0]        mean_w;

	// clamp the window length to 1..WINDOW_MAX
	always_comb begin
		if (window_len_q == '0) begin
			len_w = LEN_W'(1);
		end else if (int'(window_len_q) > WINDOW_MAX) begin
			len_w = LEN_W'(WINDOW_MAX);
		end else begin
			len_w = window_len_q;
		end
	end

	assign len_x_w     = CMP_W'(len_w);
	assign slot_x_w    = CMP_W'(slot_q);
	assign slot_inc_w  = slot_x_w + CMP_W'(1);
	assign slot_eff_w  = (slot_x_w >= len_x_w) ? '0 : slot_q;
	assign slot_next_w = (slot_inc_w >= len_x_w) ? '0 : IDX_W'(slot_inc_w);

	assign acc_idx_w = 2'(sq_cnt_q - 3'd1);
	// every magnitude fits in 32 bits, so square it on a 32x32 multiplier
	assign mag_w = diff_q[sq_cnt_q[1:0]][DIFF_W-1] ? -diff_q[sq_cnt_q[1:0]]
	                                               : diff_q[sq_cnt_q[1:0]];
	assign sq_w  = mag_w[DATA_W-1:0] * mag_w[DATA_W-1:0];

	// a slot not yet written since the window was emptied reads as zero
	assign old_w = (fill_q < len_w) ? '0 : SUM_W'(rd_q);

	assign in_acc_w     = in_valid && !in_stall;
	assign out_free_w   = !out_valid_q || !out_stall;
	assign sqrt_start_w = (state_q == ST_SQRT_GO);
	assign div_start_w  = (state_q == ST_DIV_GO);

	assign quot_x_w = {1'b0, quot_w};
	assign mean_w   = (|quot_x_w[SUM_W:DATA_W]) ? '1 : quot_w[DATA_W-1:0];

	gdsa_sqrt u_sqrt_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_w),
		.radicand (rad_d_q),
		.root     (root_d_w),
		.stat     (sq_d_stat)
	);

	gdsa_sqrt u_sqrt_speed (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_w),
		.radicand (rad_s_q),
		.root     (root_s_w),
		.stat     (sq_s_stat)
	);

	gdsa_div #(
		.N_W (SUM_W),
		.D_W (LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_w),
		.dividend (sum_q),
		.divisor  (fill_q),
		.quotient (quot_w),
		.stat     (div_stat)
	);

	// control state, configuration and window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sq_cnt_q     <= '0;
			window_len_q <= WINDOW_LEN_RST;
			target_x_q   <= '0;
			target_y_q   <= '0;
			slot_q       <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc_w) begin
						sq_cnt_q <= '0;
						state_q  <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					sq_cnt_q <= sq_cnt_q + 3'd1;
					if (sq_cnt_q == 3'd4) begin
						state_q <= ST_SQRT_GO;
					end
				end
				ST_SQRT_GO: begin
					slot_q  <= slot_eff_w;
					state_q <= ST_SQRT_WAIT;
				end
				ST_SQRT_WAIT: begin
					if (sq_s_stat.done) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					sum_q   <= sum_q - old_w;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sum_q  <= sum_q + SUM_W'(speed_q);
					slot_q <= slot_next_w;
					if (fill_q < len_w) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register frees up
					if (out_free_w) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_LEN: begin
						window_len_q <= cfg_data[LEN_W-1:0];
						slot_q       <= '0;
						fill_q       <= '0;
						sum_q        <= '0;
					end
					CFG_TARGET_X: begin
						target_x_q <= cfg_data;
					end
					CFG_TARGET_Y: begin
						target_y_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc_w) begin
			diff_q[0] <= DIFF_W'(target_x_q) - DIFF_W'(pos_x);
			diff_q[1] <= DIFF_W'(target_y_q) - DIFF_W'(pos_y);
			diff_q[2] <= DIFF_W'(vel_x);
			diff_q[3] <= DIFF_W'(vel_y);
			rad_d_q   <= '0;
			rad_s_q   <= '0;
		end
		if (state_q == ST_SQUARE) begin
			if (sq_cnt_q != 3'd4) begin
				prod_q <= RAD_W'(sq_w);
			end
			// accumulate the square from the previous cycle
			if (sq_cnt_q != 3'd0) begin
				if (acc_idx_w[1]) begin
					rad_s_q <= rad_s_q + prod_q;
				end else begin
					rad_d_q <= rad_d_q + prod_q;
				end
			end
		end
		if (state_q == ST_SQRT_WAIT && sq_s_stat.done) begin
			dist_q  <= root_d_w[ROOT_W-1] ? '1 : root_d_w[DATA_W-1:0];
			speed_q <= root_s_w[ROOT_W-1] ? '1 : root_s_w[DATA_W-1:0];
		end
		if (state_q == ST_OUT && out_free_w) begin
			goal_distance_q <= dist_q;
			mean_speed_q    <= mean_w;
		end
	end

	// speed ring: one read per sample, then write back the new magnitude
	always_ff @(posedge clk) begin
		if (state_q == ST_SQRT_GO) begin
			rd_q <= ring[slot_eff_w];
		end
		if (state_q == ST_ADD) begin
			ring[slot_q] <= speed_q;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign goal_distance = goal_distance_q;
	assign mean_speed    = mean_speed_q;

	a_sqrt_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		sq_s_stat.done |-> sq_d_stat.done && !sq_d_stat.busy)
		else $error("square root units out of step");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_w)
		else $error("fill count beyond window length");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_w |-> fill_q != '0)
		else $error("divide started with empty window");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc_w |=> in_stall && state_q == ST_SQUARE)
		else $error("accepted beat did not start the sequence");

endmodule

// ===== test/goal_distance_speed_average_top_tb.sv =====
// Self-checking testbench for goal_distance_speed_average_top.
// Depends on gdsa_pkg and the design files; a scoreboard class predicts every
// goal distance and windowed mean speed; tasks drive the input and config channels.
`timescale 1ns / 1ps

module goal_distance_speed_average_top_tb;
	import gdsa_pkg::*;

	localparam int WIN_DEPTH = 64;
	localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] goal_dist;
		logic [DATA_W-1:0] mean;
	} odo_result_t;

	class speed_goal_board;
		logic [DATA_W-1:0] speed_hist [WIN_DEPTH];
		int unsigned       hist_slot;
		int unsigned       hist_fill;
		logic [37:0]       speed_total;
		logic [LEN_W-1:0]  win_len;
		logic [DATA_W-1:0] goal_x;
		logic [DATA_W-1:0] goal_y;
		odo_result_t       expected_q[$];
		int                mismatches;

		function new();
			mismatches = 0;
			win_len = WINDOW_LEN_RST;
			goal_x = '0;
			goal_y = '0;
			clear_history();
		endfunction

		function void clear_history();
			foreach (speed_hist[i]) speed_hist[i] = '0;
			hist_slot = 0;
			hist_fill = 0;
			speed_total = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
			CFG_WINDOW_LEN: begin
				win_len = val[LEN_W-1:0];
				clear_history();
			end
			CFG_TARGET_X: goal_x = val;
			CFG_TARGET_Y: goal_y = val;
			default: ;
			endcase
		endfunction

		// floor(sqrt(a^2 + b^2)) of two 33-bit two's complement values, saturated
		function logic [DATA_W-1:0] hypot_sat(logic [32:0] a, logic [32:0] b);
			logic [32:0] ma, mb, root, trial;
			logic [65:0] rad;
			ma = a[32] ? -a : a;
			mb = b[32] ? -b : b;
			rad = {33'b0, ma} * {33'b0, ma} + {33'b0, mb} * {33'b0, mb};
			root = '0;
			for (int bit_i = 32; bit_i >= 0; bit_i--) begin
				trial = root | (33'd1 << bit_i);
				if ({33'b0, trial} * {33'b0, trial} <= rad)
					root = trial;
			end
			return root[32] ? '1 : root[31:0];
		endfunction

		function void note_sample(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
					  logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy);
			int unsigned span;
			logic [DATA_W-1:0] dist_v, spd;
			logic [37:0] avg;
			span = (win_len == 0) ? 1 : (win_len > WIN_DEPTH) ? WIN_DEPTH : win_len;
			dist_v = hypot_sat({goal_x[31], goal_x} - {px[31], px},
					   {goal_y[31], goal_y} - {py[31], py});
			spd = hypot_sat({vx[31], vx}, {vy[31], vy});
			if (hist_slot >= span)
				hist_slot = 0;
			speed_total = speed_total - speed_hist[hist_slot] + spd;
			speed_hist[hist_slot] = spd;
			hist_slot = (hist_slot + 1 >= span) ? 0 : hist_slot + 1;
			if (hist_fill < span)
				hist_fill++;
			avg = speed_total / hist_fill;
			if (avg > 38'hFFFF_FFFF)
				avg = 38'hFFFF_FFFF;
			expected_q.push_back('{goal_dist: dist_v, mean: avg[31:0]});
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		task report(string what);
			if (mismatches < 100)
				$display("MISMATCH at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic [DATA_W-1:0] d, logic [DATA_W-1:0] m);
			odo_result_t exp_r;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing outstanding dist=%h mean=%h", d, m));
				return;
			end
			exp_r = expected_q.pop_front();
			if (d !== exp_r.goal_dist)
				report($sformatf("goal_distance %h, predicted %h", d, exp_r.goal_dist));
			if (m !== exp_r.mean)
				report($sformatf("mean_speed %h, predicted %h", m, exp_r.mean));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [DATA_W-1:0]     pos_x = '0;
	logic [DATA_W-1:0]     pos_y = '0;
	logic [DATA_W-1:0]     vel_x = '0;
	logic [DATA_W-1:0]     vel_y = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [DATA_W-1:0]     goal_distance;
	logic [DATA_W-1:0]     mean_speed;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0]     cfg_data = '0;

	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	bit          hold_req = 1'b0;
	int          hold_cnt = 0;

	speed_goal_board sb = new();

	goal_distance_speed_average_top #(
		.WINDOW_MAX(WIN_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.goal_distance(goal_distance),
		.mean_speed(mean_speed),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// receiver: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 500;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(goal_distance, mean_speed);
	end

	task automatic send_sample(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
				   logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		vel_x <= vx;
		vel_y <= vy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(px, py, vx, vy);
	endtask

	// drop valid and wait until every predicted beat has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_field();
		logic [DATA_W-1:0] v;
		int unsigned pick;
		pick = $urandom_range(99);
		v = $urandom;
		if (pick < 30) begin
			v = {{12{v[31]}}, v[19:0]};
		end else if (pick < 40) begin
			case ($urandom_range(3))
			0: v = Q_MIN;
			1: v = Q_MAX;
			2: v = '0;
			default: v = '1;
			endcase
		end
		return v;
	endfunction

	// mostly legal lengths, sometimes zero or above the ring depth; junk upper bits
	function automatic logic [DATA_W-1:0] rand_window();
		logic [DATA_W-1:0] v;
		int unsigned pick;
		pick = $urandom_range(99);
		v = $urandom;
		if (pick < 60)
			v[LEN_W-1:0] = LEN_W'($urandom_range(1, 12));
		else if (pick < 85)
			v[LEN_W-1:0] = LEN_W'($urandom_range(13, WIN_DEPTH));
		else if (pick < 92)
			v[LEN_W-1:0] = '0;
		else
			v[LEN_W-1:0] = LEN_W'($urandom_range(WIN_DEPTH + 1, 127));
		return v;
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window of 8, goal at the origin
		send_sample('0, '0, '0, '0);
		send_sample(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_sample(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_sample(Q_MAX, Q_MIN, Q_MIN, Q_MAX);
		send_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		wait_drained();

		// goal in the opposite corner: distance saturates
		write_reg(CFG_TARGET_X, Q_MIN);
		write_reg(CFG_TARGET_Y, Q_MIN);
		send_sample(Q_MAX, Q_MAX, 32'h0003_0000, 32'h0004_0000);
		wait_drained();
		write_reg(CFG_TARGET_X, Q_MAX);
		write_reg(CFG_TARGET_Y, Q_MAX);
		send_sample(Q_MIN, Q_MIN, 32'hFFFD_0000, 32'h0004_0000);
		wait_drained();

		write_reg(CFG_WINDOW_LEN, 32'd1);
		send_sample(32'h0001_0000, 32'h0002_0000, Q_MAX, '0);
		send_sample(32'h0001_0000, 32'h0002_0000, 32'h0000_0005, 32'h0000_000C);
		send_sample('0, '0, '0, Q_MIN);
		wait_drained();

		// zero acts as a window of one
		write_reg(CFG_WINDOW_LEN, 32'd0);
		send_sample('1, '1, 32'h0010_0000, 32'h0010_0000);
		send_sample('1, '1, 32'h0000_0003, 32'h0000_0004);
		wait_drained();

		// moving the goal keeps the speed history
		write_reg(CFG_WINDOW_LEN, 32'd3);
		send_sample('0, '0, 32'h0000_0003, 32'h0000_0004);
		send_sample('0, '0, 32'h0000_0006, 32'h0000_0008);
		wait_drained();
		write_reg(CFG_TARGET_Y, 32'h0002_8000);
		write_reg(CFG_UNUSED, '1);
		send_sample('0, '0, 32'h0000_0000, 32'h0000_0001);
		send_sample('0, '0, 32'h0000_0007, 32'h0000_0000);
		wait_drained();

		// above the ring depth acts as the full ring
		write_reg(CFG_WINDOW_LEN, 32'd127);
		send_sample(Q_MAX, '0, 32'h0000_0009, 32'h0000_0000);
		send_sample(Q_MIN, '0, 32'h0000_0001, 32'h0000_0000);
		wait_drained();

		// rewriting the same length still empties the window
		write_reg(CFG_WINDOW_LEN, 32'd8);
		send_sample('0, '0, 32'h0000_0064, '0);
		wait_drained();
		write_reg(CFG_WINDOW_LEN, 32'd8);
		send_sample('0, '0, 32'h0000_0002, '0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin send_idle = 0; recv_stall = 0; end
			1: begin send_idle = 72; recv_stall = 0; end
			2: begin send_idle = 0; recv_stall = 72; end
			default: begin send_idle = 35; recv_stall = 35; end
			endcase
			wait_drained();
			write_reg(CFG_WINDOW_LEN, (ph == 0) ? WIN_DEPTH : rand_window());
			write_reg(CFG_TARGET_X, rand_field());
			write_reg(CFG_TARGET_Y, rand_field());
			for (int i = 0; i < 100; i++) begin
				// long receiver hold-off while samples keep coming: back up the block
				if (ph == 0 && i == 40)
					hold_req = 1'b1;
				if (i == 70) begin
					wait_drained();
					write_reg(CFG_TARGET_X, rand_field());
					if (ph[0])
						write_reg(CFG_WINDOW_LEN, rand_window());
				end
				send_sample(rand_field(), rand_field(), rand_field(), rand_field());
			end
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/gdsa_pkg.sv
design/gdsa_sqrt.sv
design/gdsa_div.sv
design/goal_distance_speed_average_top.sv
test/goal_distance_speed_average_top_tb.sv
